// File: hw/rtl/rti_pkg.sv
`timescale 1ns / 1ps
package rti_pkg;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} tri_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] distance;
	} res_t;

	// ray held in config registers, index 0..2 = x..z
	typedef struct packed {
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
	} ray_t;

	// denominator and the three numerators handed from front to back
	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] nu;
		logic signed [31:0] nv;
		logic signed [31:0] nt;
	} work_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z
	} reg_idx_t;

	localparam int FIFO_DEPTH = 2;

	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;

	function automatic logic signed [31:0] sat32(logic signed [65:0] x);
		logic signed [31:0] r;
		if (x > 66'(SMAX))
			r = SMAX;
		else if (x < 66'(SMIN))
			r = SMIN;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat_sub(logic signed [31:0] x, logic signed [31:0] y);
		logic signed [65:0] d;
		d = 66'(x) - 66'(y);
		return sat32(d);
	endfunction

	function automatic logic signed [63:0] smul(logic signed [31:0] x, logic signed [31:0] y);
		logic signed [63:0] p;
		p = 64'(x) * 64'(y);
		return p;
	endfunction

endpackage

// File: hw/rtl/ray_triangle_intersect_core.sv
`timescale 1ns / 1ps
// Ray/triangle hit test, fixed point with FRAC_BITS fraction bits in 32 bits.
// Configuration: write cfg_data to register cfg_idx while cfg_we is high
// (0..2 origin x/y/z, 3..5 direction x/y/z); do this only while no triangle
// is in flight. Other indexes are ignored.
// Requests: a triangle on req is taken at an edge with start high and busy
// low. Exactly one result per request appears on result with done high for
// one cycle, in request order.
// Pipeline: 5 front stages, the queue, 33+FRAC_BITS divider stages and 1
// output register, the first loaded at the accepting edge. The default
// FRAC_BITS of 16 gives Q16.16.
// Throughput: one request per cycle while busy is low, set by the fully
// pipelined divider; the three quotients run in parallel lanes sharing
// the divisor. busy only rises if the queue between front and divider
// fills, which the always-draining divider keeps from happening.
// Reset clears the ray registers to zero and drops all requests in flight.
// The receiver cannot stall; results are not held.
module ray_triangle_intersect_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rti_pkg::tri_t req,
	output logic          done,
	output rti_pkg::res_t result,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [31:0]   cfg_data
);
	import rti_pkg::*;

	ray_t  ray_q;
	logic  front_valid, q_full, q_valid, accept;
	work_t front_work, q_work;

	assign accept = start && !busy;
	assign busy   = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ORIGIN_X: ray_q.org[0] <= cfg_data;
				REG_ORIGIN_Y: ray_q.org[1] <= cfg_data;
				REG_ORIGIN_Z: ray_q.org[2] <= cfg_data;
				REG_DIR_X:    ray_q.dir[0] <= cfg_data;
				REG_DIR_Y:    ray_q.dir[1] <= cfg_data;
				REG_DIR_Z:    ray_q.dir[2] <= cfg_data;
				default:      ;
			endcase
		end
	end

	rti_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.tri_in   (req),
		.ray      (ray_q),
		.out_valid(front_valid),
		.work     (front_work)
	);

	rti_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.din      (front_work),
		.full     (q_full),
		.pop_valid(q_valid),
		.dout     (q_work)
	);

	rti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.work    (q_work),
		.done    (done),
		.result  (result)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.distance == '0)
		else $error("miss with nonzero distance");

	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> !result.distance[31] && result.distance != '0)
		else $error("hit with distance not positive");

	a_no_full: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid |-> !q_full)
		else $error("queue overflow");

endmodule

// File: hw/rtl/rti_front.sv
`timescale 1ns / 1ps
module rti_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  rti_pkg::tri_t  tri_in,
	input  rti_pkg::ray_t  ray,
	output logic           out_valid,
	output rti_pkg::work_t work
);
	import rti_pkg::*;

	localparam int PW = 64 - FRAC_BITS;

	logic signed [31:0] va [3], vb [3], vc [3];
	logic signed [31:0] e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [31:0] e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [31:0] e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [PW-1:0] ph_s2 [3][2], pq_s2 [3][2];
	logic signed [31:0] h_s3 [3], q_s3 [3];
	logic signed [PW-1:0] pa_s4 [3], pu_s4 [3], pv_s4 [3], pt_s4 [3];
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	work_t work_s5;

	assign va = '{tri_in.a_x, tri_in.a_y, tri_in.a_z};
	assign vb = '{tri_in.b_x, tri_in.b_y, tri_in.b_z};
	assign vc = '{tri_in.c_x, tri_in.c_y, tri_in.c_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// floor shift of a product is simply its upper bits
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			int j, k;
			logic signed [63:0] m0, m1, m2, m3;
			j = (i == 2) ? 0 : i + 1;
			k = (i == 0) ? 2 : i - 1;
			e1_s1[i] <= sat_sub(vb[i], va[i]);
			e2_s1[i] <= sat_sub(vc[i], va[i]);
			s_s1[i]  <= sat_sub($signed(ray.org[i]), va[i]);

			// h = dir x e2, q = s x e1
			m0 = smul($signed(ray.dir[j]), e2_s1[k]);
			m1 = smul($signed(ray.dir[k]), e2_s1[j]);
			m2 = smul(s_s1[j], e1_s1[k]);
			m3 = smul(s_s1[k], e1_s1[j]);
			ph_s2[i][0] <= m0[63:FRAC_BITS];
			ph_s2[i][1] <= m1[63:FRAC_BITS];
			pq_s2[i][0] <= m2[63:FRAC_BITS];
			pq_s2[i][1] <= m3[63:FRAC_BITS];
			e1_s2[i] <= e1_s1[i];
			e2_s2[i] <= e2_s1[i];
			s_s2[i]  <= s_s1[i];

			h_s3[i] <= sat32(66'(ph_s2[i][0]) - 66'(ph_s2[i][1]));
			q_s3[i] <= sat32(66'(pq_s2[i][0]) - 66'(pq_s2[i][1]));
			e1_s3[i] <= e1_s2[i];
			e2_s3[i] <= e2_s2[i];
			s_s3[i]  <= s_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic signed [63:0] m0, m1, m2, m3;
			m0 = smul(e1_s3[i], h_s3[i]);
			m1 = smul(s_s3[i], h_s3[i]);
			m2 = smul($signed(ray.dir[i]), q_s3[i]);
			m3 = smul(e2_s3[i], q_s3[i]);
			pa_s4[i] <= m0[63:FRAC_BITS];
			pu_s4[i] <= m1[63:FRAC_BITS];
			pv_s4[i] <= m2[63:FRAC_BITS];
			pt_s4[i] <= m3[63:FRAC_BITS];
		end
		work_s5.a  <= sat32(66'(pa_s4[0]) + 66'(pa_s4[1]) + 66'(pa_s4[2]));
		work_s5.nu <= sat32(66'(pu_s4[0]) + 66'(pu_s4[1]) + 66'(pu_s4[2]));
		work_s5.nv <= sat32(66'(pv_s4[0]) + 66'(pv_s4[1]) + 66'(pv_s4[2]));
		work_s5.nt <= sat32(66'(pt_s4[0]) + 66'(pt_s4[1]) + 66'(pt_s4[2]));
	end

	assign out_valid = v_s5;
	assign work      = work_s5;

endmodule

// File: hw/rtl/rti_fifo.sv
`timescale 1ns / 1ps
module rti_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rti_pkg::work_t din,
	output logic           full,
	output logic           pop_valid,
	output rti_pkg::work_t dout
);
	import rti_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	work_t          mem [FIFO_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           pop;

	// back end never stalls: pop whenever anything is queued
	assign pop       = (cnt_q != '0);
	assign pop_valid = pop;
	assign full      = (cnt_q == (AW+1)'(FIFO_DEPTH));
	assign dout      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// File: hw/rtl/rti_back.sv
`timescale 1ns / 1ps
module rti_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  rti_pkg::work_t work,
	output logic           done,
	output rti_pkg::res_t  result
);
	import rti_pkg::*;

	// quotient magnitude bits: |n| * 2^FRAC_BITS
	localparam int DW = 32 + FRAC_BITS;

	logic              vld_s [DW+1];
	logic              az_s  [DW+1];
	logic [31:0]       d_s   [DW+1];
	logic [DW-1:0]     x_s   [DW+1][3];
	logic [32:0]       r_s   [DW+1][3];
	logic              neg_s [DW+1][3];
	logic signed [31:0] num [3];
	logic signed [31:0] qv  [3];
	logic signed [32:0] uv_sum;
	logic signed [31:0] one;
	logic               hit_c;
	logic               done_q;
	res_t               res_q;

	assign num = '{work.nu, work.nv, work.nt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= DW; g++)
				vld_s[g] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int g = 0; g < DW; g++)
				vld_s[g+1] <= vld_s[g];
			done_q <= vld_s[DW];
		end
	end

	// stage 0 takes magnitudes, then one restoring step per stage
	always_ff @(posedge clk) begin
		az_s[0] <= (work.a == '0);
		d_s[0]  <= work.a[31] ? 32'(-work.a) : work.a;
		for (int l = 0; l < 3; l++) begin
			logic [31:0] nm;
			nm = num[l][31] ? 32'(-num[l]) : num[l];
			x_s[0][l]   <= {nm, {FRAC_BITS{1'b0}}};
			r_s[0][l]   <= '0;
			neg_s[0][l] <= num[l][31] ^ work.a[31];
		end
		for (int g = 0; g < DW; g++) begin
			az_s[g+1] <= az_s[g];
			d_s[g+1]  <= d_s[g];
			for (int l = 0; l < 3; l++) begin
				logic [32:0] rr;
				logic        ge;
				rr = {r_s[g][l][31:0], x_s[g][l][DW-1]};
				ge = (rr >= {1'b0, d_s[g]});
				r_s[g+1][l]   <= ge ? rr - {1'b0, d_s[g]} : rr;
				x_s[g+1][l]   <= {x_s[g][l][DW-2:0], ge};
				neg_s[g+1][l] <= neg_s[g][l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (neg_s[DW][l]) begin
				if (x_s[DW][l] > DW'(33'h080000000))
					qv[l] = SMIN;
				else
					qv[l] = 32'(-x_s[DW][l]);
			end else begin
				if (x_s[DW][l] > DW'(33'h07fffffff))
					qv[l] = SMAX;
				else
					qv[l] = x_s[DW][l][31:0];
			end
		end
		one    = 32'sd1 <<< FRAC_BITS;
		uv_sum = 33'(qv[0]) + 33'(qv[1]);
		hit_c  = !az_s[DW] && (qv[0] >= 0) && (qv[0] <= one) && (qv[1] >= 0) &&
			(uv_sum <= 33'(one)) && (qv[2] > 0);
	end

	always_ff @(posedge clk) begin
		res_q.hit      <= hit_c;
		res_q.distance <= hit_c ? qv[2] : '0;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
